// ----- hdl/pps_pkg.sv -----
// Package for the polar plotter step generator: operation codes, register
// indexes, the front/back queue entry type and the back-end FSM state type.
// No dependencies.
package pps_pkg;

  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [1:0] {
    OP_TARGET = 2'd0,
    OP_TICK   = 2'd1,
    OP_HOME   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SPAN     = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_PERIOD   = 3'd5,
    REG_LPULL    = 3'd6,
    REG_RPULL    = 3'd7
  } reg_e;

  // Queue entry: classified op plus scaled point in step units.
  typedef struct packed {
    op_e                op;
    logic signed [25:0] wx;
    logic signed [25:0] h;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_L,
    ST_SQ_R,
    ST_ROOT_L,
    ST_ROOT_R,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } bk_state_e;

endpackage

// ----- hdl/pps_front.sv -----
// Front end: accepts items and scales the point to step units.
// Depends on pps_pkg.
module pps_front
  import pps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic [23:0]        origin_x_i,
  input  logic [23:0]        origin_y_i,
  input  logic [15:0]        scale_x_i,
  input  logic [15:0]        scale_y_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  logic               full_q;
  cmd_t               cmd_q;
  logic signed [32:0] px, py;
  logic signed [25:0] wx, hy;

  // Arithmetic shift floors toward minus infinity.
  assign px = (33'(target_x_i) * $signed({1'b0, scale_x_i})) >>> 8;
  assign py = (33'(target_y_i) * $signed({1'b0, scale_y_i})) >>> 8;
  assign wx = 26'($signed(origin_x_i)) + 26'(px);
  assign hy = 26'($signed(origin_y_i)) + 26'(py);

  assign in_stall_o  = full_q && !cmd_ready_i;
  assign cmd_valid_o = full_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (!in_stall_o) begin
      full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q.op <= op_e'(operation_i);
      cmd_q.wx <= wx;
      cmd_q.h  <= hy;
    end
  end

endmodule

// ----- hdl/pps_fifo.sv -----
// Two-entry queue between front and back end.
// Depends on pps_pkg.
module pps_fifo
  import pps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ----- hdl/pps_back.sv -----
// Back end: cord kinematics (serial square root and divider), tick stepping
// and the output register. Depends on pps_pkg.
module pps_back
  import pps_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic [23:0] span_steps_i,
  input  logic [15:0] step_period_i,
  input  logic        left_pull_level_i,
  input  logic        right_pull_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        left_step_level_o,
  output logic        left_dir_level_o,
  output logic        right_step_level_o,
  output logic        right_dir_level_o,
  output logic        busy_res_o,
  output logic        rejected_o,
  output logic [23:0] left_length_o,
  output logic [23:0] right_length_o
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
  localparam logic [LB-1:0] LenMax = {LB{1'b1}};

  bk_state_e state_q, state_d;

  logic [LB-1:0] lcord_q, rcord_q, lrem_q, rrem_q;
  logic [31:0]   lint_q, rint_q, lel_q, rel_q;
  logic          lpull_q, rpull_q;

  cmd_t          c_q;
  logic [55:0]   sq_q;      // radicand
  logic [54:0]   rad_q;
  logic [27:0]   root_q;
  logic [4:0]    it_q;
  logic [LB-1:0] lt_q, rt_q;
  logic [LB-1:0] lg_q, sh_q;
  logic          lleft_q;
  logic [LB+15:0] num_q;
  logic [LB+15:0] quo_q;
  logic [LB:0]    rm_q;
  logic [5:0]     dit_q;

  logic          ov_q, rej_q;
  logic [23:0]   oll_q, orl_q;
  logic          oldir_q, ordir_q, obusy_q, orej_q;

  // combinational helpers
  logic [25:0]   aw, ah, ar, am;
  logic signed [26:0] rw;
  logic [51:0]   sqa, sqh;
  logic [55:0]   trial;
  logic [54:0]   cur;
  logic [27:0]   root_nx;
  logic [LB:0]   rsh;
  logic          take;
  logic signed [LB+1:0] dl, dr;
  logic [LB-1:0] ldl, ldr;
  logic [LB-1:0] root_sat;
  logic          busy;
  logic [31:0]   lel_n, rel_n;
  logic          lstep, rstep;

  assign busy = (lrem_q != '0) || (rrem_q != '0);
  assign aw   = c_q.wx[25] ? 26'(-c_q.wx) : 26'(c_q.wx);
  assign ah   = c_q.h[25] ? 26'(-c_q.h) : 26'(c_q.h);
  assign rw   = $signed({3'b0, span_steps_i}) - 27'(c_q.wx);
  assign ar   = 26'(rw[26] ? -rw : rw);
  // left uses |wx|, right uses |span-wx|
  assign am   = (state_q == ST_SQ_R) ? ar : aw;
  assign sqa  = am * am;
  assign sqh  = ah * ah;

  // restoring square root, two radicand bits per cycle
  assign cur   = {rad_q[52:0], sq_q[55:54]};
  assign trial = {1'b0, cur} - {26'b0, root_q, 2'b01};
  assign root_nx  = {root_q[26:0], !trial[55]};
  assign root_sat = (root_nx > 28'(LenMax)) ? LenMax : LB'(root_nx);

  assign dl  = $signed({2'b0, lt_q}) - $signed({2'b0, lcord_q});
  assign dr  = $signed({2'b0, rt_q}) - $signed({2'b0, rcord_q});
  assign ldl = LB'(dl[LB+1] ? -dl : dl);
  assign ldr = LB'(dr[LB+1] ? -dr : dr);

  // restoring divider, one quotient bit per cycle
  assign rsh  = {rm_q[LB-1:0], num_q[LB+15]};
  assign take = rsh >= {1'b0, sh_q};

  assign lel_n = (lel_q != Sat32) ? lel_q + 32'd1 : lel_q;
  assign rel_n = (rel_q != Sat32) ? rel_q + 32'd1 : rel_q;
  assign lstep = (lrem_q != '0) && (lel_n >= lint_q);
  assign rstep = (rrem_q != '0) && (rel_n >= rint_q);

  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if ((cmd_i.op == OP_TARGET || cmd_i.op == OP_HOME) && !busy) begin
            state_d = ST_SQ_L;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SQ_L:   state_d = ST_ROOT_L;
      ST_ROOT_L: if (it_q == 5'd27) state_d = ST_SQ_R;
      ST_SQ_R:   state_d = ST_ROOT_R;
      ST_ROOT_R: if (it_q == 5'd27) state_d = ST_DELTA;
      ST_DELTA:  state_d = (c_q.op == OP_HOME) ? ST_OUT : ST_MUL;
      ST_MUL:    state_d = (sh_q == '0) ? ST_DONE : ST_DIV;
      ST_DIV:    if (dit_q == 6'(LB + 15)) state_d = ST_DONE;
      ST_DONE:   state_d = ST_OUT;
      ST_OUT:    if (!ov_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lcord_q <= '0; rcord_q <= '0; lrem_q <= '0; rrem_q <= '0;
      lint_q <= '0; rint_q <= '0; lel_q <= '0; rel_q <= '0;
      lpull_q <= 1'b0; rpull_q <= 1'b0;
      ov_q <= 1'b0; rej_q <= 1'b0;
      it_q <= '0; dit_q <= '0;
      oll_q <= '0; orl_q <= '0;
      oldir_q <= 1'b0; ordir_q <= 1'b0; obusy_q <= 1'b0; orej_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            rej_q <= (cmd_i.op == OP_TARGET || cmd_i.op == OP_HOME) && busy;
            if (cmd_i.op == OP_TICK) begin
              if (lrem_q != '0) begin
                lel_q <= lstep ? 32'd0 : lel_n;
                if (lstep) begin
                  lrem_q  <= lrem_q - LB'(1);
                  lcord_q <= lpull_q ? lcord_q - LB'(1) : lcord_q + LB'(1);
                end
              end
              if (rrem_q != '0) begin
                rel_q <= rstep ? 32'd0 : rel_n;
                if (rstep) begin
                  rrem_q  <= rrem_q - LB'(1);
                  rcord_q <= rpull_q ? rcord_q - LB'(1) : rcord_q + LB'(1);
                end
              end
            end
          end
          it_q <= '0;
        end
        ST_SQ_L, ST_SQ_R: it_q <= '0;
        ST_ROOT_L, ST_ROOT_R: it_q <= it_q + 5'd1;
        ST_DELTA: begin
          if (c_q.op == OP_HOME) begin
            lcord_q <= lt_q; rcord_q <= rt_q;
            lrem_q <= '0; rrem_q <= '0;
          end else begin
            lpull_q <= dl[LB+1]; rpull_q <= dr[LB+1];
            lrem_q <= ldl; rrem_q <= ldr;
            lel_q <= '0; rel_q <= '0;
          end
        end
        ST_MUL: dit_q <= '0;
        ST_DIV: dit_q <= dit_q + 6'd1;
        ST_DONE: begin
          if (lleft_q) lint_q <= 32'(step_period_i);
          else rint_q <= 32'(step_period_i);
        end
        ST_OUT: begin
          if (!ov_q) begin
            ov_q    <= 1'b1;
            oll_q   <= 24'(lcord_q);
            orl_q   <= 24'(rcord_q);
            oldir_q <= lpull_q ? left_pull_level_i : !left_pull_level_i;
            ordir_q <= rpull_q ? right_pull_level_i : !right_pull_level_i;
            obusy_q <= busy;
            orej_q  <= rej_q;
          end
        end
        default: ;
      endcase
      if (state_q == ST_DONE) begin
        if (lleft_q) rint_q <= (sh_q == '0 || quo_q > (LB+16)'(Sat32)) ? Sat32
                                  : 32'(quo_q);
        else lint_q <= (sh_q == '0 || quo_q > (LB+16)'(Sat32)) ? Sat32
                          : 32'(quo_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (cmd_valid_i) c_q <= cmd_i;
      ST_SQ_L, ST_SQ_R: begin
        sq_q   <= 56'(sqa) + 56'(sqh);
        rad_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT_L, ST_ROOT_R: begin
        sq_q <= {sq_q[53:0], 2'b00};
        if (!trial[55]) begin
          rad_q  <= trial[54:0];
          root_q <= {root_q[26:0], 1'b1};
        end else begin
          rad_q  <= cur;
          root_q <= {root_q[26:0], 1'b0};
        end
      end
      ST_DELTA: begin
        lleft_q <= ldl > ldr;
        lg_q    <= (ldl > ldr) ? ldl : ldr;
        sh_q    <= (ldl > ldr) ? ldr : ldl;
      end
      ST_MUL: begin
        num_q <= (LB+16)'(step_period_i) * (LB+16)'(lg_q) + (LB+16)'(sh_q)
                 - (LB+16)'(1);
        rm_q  <= '0;
        quo_q <= '0;
      end
      ST_DIV: begin
        num_q <= {num_q[LB+14:0], 1'b0};
        rm_q  <= take ? rsh - {1'b0, sh_q} : rsh;
        quo_q <= {quo_q[LB+14:0], take};
      end
      default: ;
    endcase
    if (state_q == ST_ROOT_L && it_q == 5'd27) lt_q <= root_sat;
    if (state_q == ST_ROOT_R && it_q == 5'd27) rt_q <= root_sat;
  end

  assign out_valid_o        = ov_q;
  assign left_step_level_o  = oll_q[0];
  assign left_dir_level_o   = oldir_q;
  assign right_step_level_o = orl_q[0];
  assign right_dir_level_o  = ordir_q;
  assign busy_res_o         = obusy_q;
  assign rejected_o         = orej_q;
  assign left_length_o      = oll_q;
  assign right_length_o     = orl_q;

endmodule

// ----- hdl/polar_plotter_step_generator.sv -----
// Polar plotter step generator, top level: config registers, front end,
// queue and back end. Depends on pps_pkg, pps_front, pps_fifo, pps_back.
// A tick, rejected or no-op item goes straight from the back end's idle state
// to its output state; a home item first passes the two 28-step serial square
// roots, and a target item passes them and then the LENGTH_BITS+16 step serial
// divider, skipped when the shorter cord does not move. The back end takes one
// item at a time; a stalled result holds the next one in the back end, and the
// queue and front buffer then fill.
module polar_plotter_step_generator
  import pps_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               left_step_level_o,
  output logic               left_dir_level_o,
  output logic               right_step_level_o,
  output logic               right_dir_level_o,
  output logic               busy_res_o,
  output logic               rejected_o,
  output logic [23:0]        left_length_o,
  output logic [23:0]        right_length_o
);

  logic [23:0] span_q, ox_q, oy_q;
  logic [15:0] sx_q, sy_q, per_q;
  logic        lpl_q, rpl_q;
  logic        fv, fr, qv, qr;
  cmd_t        fc, qc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0; ox_q <= '0; oy_q <= '0;
      sx_q <= 16'd256; sy_q <= 16'd256; per_q <= 16'd1000;
      lpl_q <= 1'b0; rpl_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_SPAN:     span_q <= cfg_data_i;
        REG_ORIGIN_X: ox_q   <= cfg_data_i;
        REG_ORIGIN_Y: oy_q   <= cfg_data_i;
        REG_SCALE_X:  sx_q   <= cfg_data_i[15:0];
        REG_SCALE_Y:  sy_q   <= cfg_data_i[15:0];
        REG_PERIOD:   per_q  <= cfg_data_i[15:0];
        REG_LPULL:    lpl_q  <= cfg_data_i[0];
        REG_RPULL:    rpl_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pps_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .target_x_i,
    .target_y_i, .origin_x_i(ox_q), .origin_y_i(oy_q), .scale_x_i(sx_q),
    .scale_y_i(sy_q), .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fc)
  );

  pps_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fc),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qc)
  );

  pps_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qc),
    .span_steps_i(span_q), .step_period_i(per_q),
    .left_pull_level_i(lpl_q), .right_pull_level_i(rpl_q),
    .out_valid_o, .out_stall_i, .left_step_level_o, .left_dir_level_o,
    .right_step_level_o, .right_dir_level_o, .busy_res_o, .rejected_o,
    .left_length_o, .right_length_o
  );

endmodule

// ----- hdl/pps_checker.sv -----
// Port-level checker for the polar plotter step generator, bound to the top.
// No dependencies beyond the top level's ports.
module pps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        busy_res_o,
  input logic        rejected_o,
  input logic [23:0] left_length_o,
  input logic        left_step_level_o,
  input logic [23:0] right_length_o,
  input logic        right_step_level_o
);

  a_lstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_step_level_o == left_length_o[0]) else $error("lstep");
  a_rstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_step_level_o == right_length_o[0]) else $error("rstep");
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o) else $error("rej");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_length_o))
    else $error("hold");

endmodule

bind polar_plotter_step_generator pps_checker u_chk (.*);
